>>> hw/rtl/triangle_transform_cull_project_macros.svh
// Assertion macros used by the triangle transform top level.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef TRIANGLE_TRANSFORM_CULL_PROJECT_MACROS_SVH
`define TRIANGLE_TRANSFORM_CULL_PROJECT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tcp_pkg.sv
// Package for the triangle transform/cull/project block: widths, constants,
// register codes, the configuration struct and a clamp function. Depends on nothing.
package tcp_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // Fixed field widths
    localparam int TAG_W   = 12;
    localparam int TRIG_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int SIZE_W  = 10;
    localparam int SHADE_W = 3;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Rotation rounding and transformed-vertex width
    localparam int TRIG_SHIFT = 14;
    localparam int GEO_BITS   = 27;
    localparam int XLATE_INT  = 3;

    // Projection scaling: sx = W*(2^11*z + x*xg)/(2^8*z), sy = H*(2^12*z + y*yg)/(2^9*z)
    localparam int X_HALF_SHIFT = 11;
    localparam int X_DEN_SHIFT  = 8;
    localparam int Y_HALF_SHIFT = 12;
    localparam int Y_DEN_SHIFT  = 9;
    localparam int ZERO_SCALE   = 3;

    // Normal / cull / shade widths
    localparam int E_W   = GEO_BITS + 1;
    localparam int N_W   = 2 * E_W;
    localparam int M_W   = N_W - 1;
    localparam int LO_W  = E_W;
    localparam int HI_W  = M_W - LO_W;
    localparam int SQ_W  = 2 * M_W;
    localparam int S_W   = SQ_W + 2;
    localparam int LHS_W = SQ_W + 7;
    localparam int RHS_W = S_W + 7;
    localparam int DP_W  = N_W + GEO_BITS;
    localparam int DOT_W = DP_W + 2;

    // Shade thresholds: (10*nz)^2 >= (k*|N|)^2 for k = 9 down to 3
    localparam int SHADE_K_MIN = 3;
    localparam int SHADE_K_MAX = 9;
    localparam logic [SHADE_W-1:0] SHADE_FLAT = 3'd7;

    // Pipeline depth from accept to the first merge level register
    localparam int MERGE_LAT = 10;

    typedef enum logic [IDX_W-1:0] {
        REG_COS_ROLL,
        REG_SIN_ROLL,
        REG_COS_PITCH,
        REG_SIN_PITCH,
        REG_X_GAIN,
        REG_Y_GAIN,
        REG_SCREEN_W,
        REG_SCREEN_H
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_roll;
        logic signed [TRIG_W-1:0] sin_roll;
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic [GAIN_W-1:0]        x_gain;
        logic [GAIN_W-1:0]        y_gain;
        logic [SIZE_W-1:0]        screen_width;
        logic [SIZE_W-1:0]        screen_height;
    } cfg_t;

    localparam logic signed [63:0] GEO_MAX = (64'sd1 <<< (GEO_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] GEO_MIN = -GEO_MAX - 64'sd1;

    // Clamp to the transformed-vertex range
    function automatic logic signed [GEO_BITS-1:0] sat_geo(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > GEO_MAX) begin
            r = GEO_MAX;
        end else if (v < GEO_MIN) begin
            r = GEO_MIN;
        end else begin
            r = v;
        end
        return r[GEO_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/tcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, floor rounding and
// saturation to a signed Q_W result. Depends on tcp_pkg.
module tcp_div import tcp_pkg::*; #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 36,
    parameter int Q_W   = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [Q_W-1:0]   quo
);

    localparam int RW = DEN_W + Q_W;
    localparam int CW = (NUM_W > RW) ? NUM_W : RW;
    localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W - 1){1'b0}}};
    localparam logic [Q_W:0] QLIM = (Q_W + 1)'(1) << (Q_W - 1);

    logic [NUM_W-1:0] nm;
    logic [DEN_W-1:0] dm;
    logic             ovf;

    logic [RW-1:0]    rem_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [DEN_W-1:0] dm_reg  [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic signed [Q_W-1:0] quo_reg, quo_next;

    // Magnitudes and quotient overflow check
    assign nm  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dm  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign ovf = CW'(nm) >= (CW'(dm) << Q_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= ovf ? '0 : RW'(nm);
            q_reg[0]   <= '0;
            dm_reg[0]  <= dm;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            ovf_reg[0] <= ovf;
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar j = 1; j <= Q_W; j++) begin : g_step
        logic [RW-1:0] trial;
        assign trial = RW'(dm_reg[j-1]) << (Q_W - j);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[j-1] >= trial) begin
                    rem_reg[j] <= rem_reg[j-1] - trial;
                    q_reg[j]   <= q_reg[j-1] | (Q_W'(1) << (Q_W - j));
                end else begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
                dm_reg[j]  <= dm_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // Floor correction for mixed signs, then saturate
    always_comb begin
        logic [Q_W:0] qa;
        qa = {1'b0, q_reg[Q_W]} + (Q_W + 1)'(|rem_reg[Q_W]);
        if (!neg_reg[Q_W]) begin
            quo_next = (ovf_reg[Q_W] || q_reg[Q_W][Q_W-1]) ? QMAX : signed'(q_reg[Q_W]);
        end else if (ovf_reg[Q_W] || qa > QLIM) begin
            quo_next = QMIN;
        end else begin
            quo_next = Q_W'(-qa);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> hw/rtl/tcp_lane.sv
// One vertex lane: two rotations, translation, projection terms and two
// dividers for the screen coordinates. Depends on tcp_pkg and tcp_div.
module tcp_lane import tcp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  cfg_t                         cfg,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    output logic signed [GEO_BITS-1:0]   vx,
    output logic signed [GEO_BITS-1:0]   vy,
    output logic signed [GEO_BITS-1:0]   vz,
    output logic signed [COORD_BITS-1:0] sx,
    output logic signed [COORD_BITS-1:0] sy,
    output logic                         fault
);

    localparam int R1_W  = COORD_BITS + TRIG_W + 1;
    localparam int A_W   = R1_W - TRIG_SHIFT;
    localparam int R2_W  = A_W + TRIG_W + 1;
    localparam int B_W   = COORD_BITS + FRAC_BITS + 3;
    localparam int SUM_W = GEO_BITS + GAIN_W + 2;
    localparam int NUM_W = SUM_W + SIZE_W + 1;
    localparam int DEN_W = GEO_BITS + Y_DEN_SHIFT;
    localparam int FL_N  = COORD_BITS + 4;
    localparam logic signed [R1_W-1:0] RND1 = R1_W'(1) << (TRIG_SHIFT - 1);
    localparam logic signed [R2_W-1:0] RND2 = R2_W'(1) << (TRIG_SHIFT - 1);
    localparam logic signed [B_W-1:0]  XLATE = B_W'(XLATE_INT) << FRAC_BITS;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    typedef struct packed {
        logic zero;
        logic xpos;
        logic xneg;
        logic ypos;
        logic yneg;
    } zflags_t;

    logic signed [R1_W-1:0] t1, t2;
    logic signed [A_W-1:0]  x1_reg, y1_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic signed [R2_W-1:0] u2, w2;
    logic signed [B_W-1:0]  y2, z2;
    logic signed [GEO_BITS-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [SUM_W-1:0] px, py, sumx_reg, sumy_reg;
    logic signed [DEN_W-1:0] dx_reg, dy_reg, dx2_reg, dy2_reg;
    logic signed [NUM_W-1:0] numx_reg, numy_reg;
    logic signed [GAIN_W:0]  xg_s, yg_s;
    logic signed [SIZE_W:0]  w_s, h_s;
    zflags_t fl_reg [0:FL_N-1];
    zflags_t fl_end;
    logic signed [COORD_BITS-1:0] qx, qy, zx, zy;
    logic [SIZE_W+ZERO_SCALE-1:0] w8, h8;

    // First rotation, about z
    assign t1 = in_x * cfg.cos_roll + in_y * cfg.sin_roll;
    assign t2 = in_y * cfg.cos_roll - in_x * cfg.sin_roll;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= A_W'((t1 + RND1) >>> TRIG_SHIFT);
            y1_reg <= A_W'((t2 + RND1) >>> TRIG_SHIFT);
            z_reg  <= in_z;
        end
    end

    // Second rotation about x, translate, clamp
    assign u2 = y1_reg * cfg.cos_pitch + z_reg * cfg.sin_pitch;
    assign w2 = z_reg * cfg.cos_pitch - y1_reg * cfg.sin_pitch;
    assign y2 = B_W'((u2 + RND2) >>> TRIG_SHIFT);
    assign z2 = B_W'((w2 + RND2) >>> TRIG_SHIFT) + XLATE;

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= sat_geo(64'(x1_reg));
            vy_reg <= sat_geo(64'(y2));
            vz_reg <= sat_geo(64'(z2));
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;
    assign vz = vz_reg;

    // Projection numerator terms and denominators
    assign xg_s = {1'b0, cfg.x_gain};
    assign yg_s = {1'b0, cfg.y_gain};
    assign px   = vx_reg * xg_s;
    assign py   = vy_reg * yg_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            sumx_reg <= px + (SUM_W'(vz_reg) <<< X_HALF_SHIFT);
            sumy_reg <= py + (SUM_W'(vz_reg) <<< Y_HALF_SHIFT);
            dx_reg   <= DEN_W'(vz_reg) <<< X_DEN_SHIFT;
            dy_reg   <= DEN_W'(vz_reg) <<< Y_DEN_SHIFT;
            fl_reg[0] <= '{zero: (vz_reg == '0),
                           xpos: (vx_reg > 0), xneg: vx_reg[GEO_BITS-1],
                           ypos: (vy_reg > 0), yneg: vy_reg[GEO_BITS-1]};
        end
    end

    // Scale by screen size
    assign w_s = {1'b0, cfg.screen_width};
    assign h_s = {1'b0, cfg.screen_height};

    always_ff @(posedge aclk) begin
        if (en) begin
            numx_reg <= sumx_reg * w_s;
            numy_reg <= sumy_reg * h_s;
            dx2_reg  <= dx_reg;
            dy2_reg  <= dy_reg;
        end
    end

    // Zero-depth flags ride alongside the dividers
    for (genvar k = 1; k < FL_N; k++) begin : g_flag
        always_ff @(posedge aclk) begin
            if (en) begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    tcp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(COORD_BITS)) u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (numx_reg),
        .den  (dx2_reg),
        .quo  (qx)
    );

    tcp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(COORD_BITS)) u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (numy_reg),
        .den  (dy2_reg),
        .quo  (qy)
    );

    // Zero depth: clamp by sign of the coordinate, centered value when it is zero
    assign fl_end = fl_reg[FL_N-1];
    assign w8 = {cfg.screen_width, ZERO_SCALE'(0)};
    assign h8 = {cfg.screen_height, ZERO_SCALE'(0)};
    assign zx = (33'(w8) > 33'(CMAX)) ? CMAX : COORD_BITS'(w8);
    assign zy = (33'(h8) > 33'(CMAX)) ? CMAX : COORD_BITS'(h8);

    always_comb begin
        if (!fl_end.zero) begin
            sx = qx;
            sy = qy;
        end else begin
            sx = fl_end.xpos ? CMAX : (fl_end.xneg ? CMIN : zx);
            sy = fl_end.ypos ? CMAX : (fl_end.yneg ? CMIN : zy);
        end
    end

    assign fault = fl_end.zero;

endmodule

>>> hw/rtl/tcp_merge.sv
// Merging stage: face normal from the three lanes, back-face test and shade
// level, delayed to meet the lanes' screen results. Depends on tcp_pkg.
module tcp_merge import tcp_pkg::*; #(
    parameter int PAD = 8
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [GEO_BITS-1:0] vx [3],
    input  logic signed [GEO_BITS-1:0] vy [3],
    input  logic signed [GEO_BITS-1:0] vz [3],
    output logic                       visible,
    output logic [SHADE_W-1:0]         level
);

    logic signed [GEO_BITS-1:0] co [3][3];
    logic signed [E_W-1:0] e1_reg [3];
    logic signed [E_W-1:0] e2_reg [3];
    logic signed [GEO_BITS-1:0] a1_reg [3];
    logic signed [GEO_BITS-1:0] a2_reg [3];
    logic signed [GEO_BITS-1:0] a3_reg [3];
    logic signed [N_W-1:0] pr_reg [6];
    logic signed [N_W-1:0] n_reg [3];
    logic [2*LO_W-1:0]     ml2_reg [3];
    logic [M_W-1:0]        mhl_reg [3];
    logic [2*HI_W-1:0]     mh2_reg [3];
    logic signed [LO_W+GEO_BITS:0]  dl_reg [3];
    logic signed [N_W-LO_W+GEO_BITS-1:0] dh_reg [3];
    logic [SQ_W-1:0]       sq_reg [3];
    logic signed [DP_W-1:0] dp_reg [3];
    logic                  nzneg4_reg, nzneg5_reg, nzneg6_reg, nzneg7_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [S_W-1:0]        s_reg;
    logic [LHS_W-1:0]      lhs6_reg, lhs7_reg;
    logic [RHS_W-1:0]      rhs_reg [SHADE_K_MIN:SHADE_K_MAX];
    logic                  vis7_reg;
    logic                  vis_reg [0:PAD];
    logic [SHADE_W-1:0]    lvl_reg [0:PAD];
    logic [SHADE_W-1:0]    lvl_next;

    for (genvar i = 0; i < 3; i++) begin : g_co
        assign co[i][0] = vx[i];
        assign co[i][1] = vy[i];
        assign co[i][2] = vz[i];
    end

    // Edges from the first vertex; keep the first vertex for the dot product
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                e1_reg[a] <= E_W'(co[1][a]) - E_W'(co[0][a]);
                e2_reg[a] <= E_W'(co[2][a]) - E_W'(co[0][a]);
                a1_reg[a] <= co[0][a];
                a2_reg[a] <= a1_reg[a];
                a3_reg[a] <= a2_reg[a];
            end
        end
    end

    // Cross-product terms, then the normal
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int a = 0; a < 3; a++) begin
                n_reg[a] <= pr_reg[2*a] - pr_reg[2*a+1];
            end
        end
    end

    // Partial products for |n|^2 and for n . a, split to narrow multipliers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                logic [N_W-1:0] mabs;
                logic [LO_W-1:0] ml;
                logic [HI_W-1:0] mh;
                mabs = n_reg[a][N_W-1] ? N_W'(-n_reg[a]) : N_W'(n_reg[a]);
                ml   = mabs[LO_W-1:0];
                mh   = mabs[M_W-1:LO_W];
                ml2_reg[a] <= ml * ml;
                mhl_reg[a] <= mh * ml;
                mh2_reg[a] <= mh * mh;
                dl_reg[a]  <= signed'({1'b0, n_reg[a][LO_W-1:0]}) * a3_reg[a];
                dh_reg[a]  <= signed'(n_reg[a][N_W-1:LO_W]) * a3_reg[a];
            end
            nzneg4_reg <= n_reg[2][N_W-1];
        end
    end

    // Recombine partial products per axis
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                sq_reg[a] <= (SQ_W'(mh2_reg[a]) << (2 * LO_W))
                           + (SQ_W'(mhl_reg[a]) << (LO_W + 1))
                           + SQ_W'(ml2_reg[a]);
                dp_reg[a] <= (DP_W'(dh_reg[a]) <<< LO_W) + DP_W'(dl_reg[a]);
            end
            nzneg5_reg <= nzneg4_reg;
        end
    end

    // Sums: dot product, squared length, scaled nz^2
    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg  <= DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
            s_reg    <= S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
            lhs6_reg <= (LHS_W'(sq_reg[2]) << 6) + (LHS_W'(sq_reg[2]) << 5)
                      + (LHS_W'(sq_reg[2]) << 2);
            nzneg6_reg <= nzneg5_reg;
        end
    end

    // Threshold products k^2 * |N|^2 and the cull decision
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = SHADE_K_MIN; k <= SHADE_K_MAX; k++) begin
                rhs_reg[k] <= RHS_W'(s_reg) * RHS_W'(k * k);
            end
            lhs7_reg   <= lhs6_reg;
            vis7_reg   <= dot_reg[DOT_W-1];
            nzneg7_reg <= nzneg6_reg;
        end
    end

    // Largest k that passes sets the level
    always_comb begin
        lvl_next = SHADE_FLAT;
        if (nzneg7_reg) begin
            for (int k = SHADE_K_MIN; k <= SHADE_K_MAX; k++) begin
                if (RHS_W'(lhs7_reg) >= rhs_reg[k]) begin
                    lvl_next = SHADE_W'(SHADE_K_MAX - k);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis_reg[0] <= vis7_reg;
            lvl_reg[0] <= lvl_next;
        end
    end

    // Align with the lane dividers
    for (genvar k = 1; k <= PAD; k++) begin : g_pad
        always_ff @(posedge aclk) begin
            if (en) begin
                vis_reg[k] <= vis_reg[k-1];
                lvl_reg[k] <= lvl_reg[k-1];
            end
        end
    end

    assign visible = vis_reg[PAD];
    assign level   = lvl_reg[PAD];

endmodule

>>> hw/rtl/triangle_transform_cull_project.sv
// Top level: configuration registers, three vertex lanes, the merge stage,
// valid/tag pipeline and the result register. Depends on tcp_pkg, tcp_lane,
// tcp_merge and the assertion macros header.
//
//  channel | direction | handshake           | carries
//  s_      | in        | s_valid / s_ready   | tag and three model-space vertices
//  m_      | out       | m_valid / m_ready   | tag, screen vertices, shade, depth fault
//  cfg_    | in        | cfg_we (no wait)    | one register write per beat
//
// One triangle per cycle sustained while no result is held; the depth from accept
// to result is set by the one-bit-per-stage dividers in each lane.
// Culled triangles leave no result; their slot simply empties.
// Reset clears the valid pipeline and result valid and loads the configuration defaults; no sweep.
// A held result stalls the whole pipeline, and s_ready drops with it.
`include "triangle_transform_cull_project_macros.svh"

module triangle_transform_cull_project import tcp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [IDX_W-1:0]             cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [TAG_W-1:0]             s_tri_tag,
    input  logic signed [COORD_BITS-1:0] s_ax,
    input  logic signed [COORD_BITS-1:0] s_ay,
    input  logic signed [COORD_BITS-1:0] s_az,
    input  logic signed [COORD_BITS-1:0] s_bx,
    input  logic signed [COORD_BITS-1:0] s_by_coord,
    input  logic signed [COORD_BITS-1:0] s_bz,
    input  logic signed [COORD_BITS-1:0] s_cx,
    input  logic signed [COORD_BITS-1:0] s_cy,
    input  logic signed [COORD_BITS-1:0] s_cz,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [TAG_W-1:0]             m_out_tag,
    output logic signed [COORD_BITS-1:0] m_sx_a,
    output logic signed [COORD_BITS-1:0] m_sy_a,
    output logic signed [COORD_BITS-1:0] m_sx_b,
    output logic signed [COORD_BITS-1:0] m_sy_b,
    output logic signed [COORD_BITS-1:0] m_sx_c,
    output logic signed [COORD_BITS-1:0] m_sy_c,
    output logic [SHADE_W-1:0]           m_shade_level,
    output logic                         m_depth_fault
);

    localparam int LAT = COORD_BITS + 6;
    localparam int PAD = LAT - MERGE_LAT;

    cfg_t cfg_reg;
    logic en;
    logic [LAT-1:0]   vld_reg;
    logic [TAG_W-1:0] tag_reg [0:LAT-1];

    logic signed [COORD_BITS-1:0] in_x [3];
    logic signed [COORD_BITS-1:0] in_y [3];
    logic signed [COORD_BITS-1:0] in_z [3];
    logic signed [GEO_BITS-1:0]   vx [3];
    logic signed [GEO_BITS-1:0]   vy [3];
    logic signed [GEO_BITS-1:0]   vz [3];
    logic signed [COORD_BITS-1:0] sx [3];
    logic signed [COORD_BITS-1:0] sy [3];
    logic [2:0]                   flt;
    logic                         visible;
    logic [SHADE_W-1:0]           level;

    logic                         m_valid_reg;
    logic [TAG_W-1:0]             tag_out_reg;
    logic signed [COORD_BITS-1:0] sx_reg [3];
    logic signed [COORD_BITS-1:0] sy_reg [3];
    logic [SHADE_W-1:0]           shade_reg;
    logic                         fault_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_roll      <= 16'sd16384;
            cfg_reg.sin_roll      <= '0;
            cfg_reg.cos_pitch     <= 16'sd16384;
            cfg_reg.sin_pitch     <= '0;
            cfg_reg.x_gain        <= 16'd4096;
            cfg_reg.y_gain        <= 16'd4096;
            cfg_reg.screen_width  <= 10'd80;
            cfg_reg.screen_height <= 10'd24;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_COS_ROLL:  cfg_reg.cos_roll      <= signed'(cfg_wdata);
                REG_SIN_ROLL:  cfg_reg.sin_roll      <= signed'(cfg_wdata);
                REG_COS_PITCH: cfg_reg.cos_pitch     <= signed'(cfg_wdata);
                REG_SIN_PITCH: cfg_reg.sin_pitch     <= signed'(cfg_wdata);
                REG_X_GAIN:    cfg_reg.x_gain        <= cfg_wdata;
                REG_Y_GAIN:    cfg_reg.y_gain        <= cfg_wdata;
                REG_SCREEN_W:  cfg_reg.screen_width  <= cfg_wdata[SIZE_W-1:0];
                REG_SCREEN_H:  cfg_reg.screen_height <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a result is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= s_tri_tag;
            for (int k = 1; k < LAT; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Vertex lanes
    assign in_x[0] = s_ax;
    assign in_y[0] = s_ay;
    assign in_z[0] = s_az;
    assign in_x[1] = s_bx;
    assign in_y[1] = s_by_coord;
    assign in_z[1] = s_bz;
    assign in_x[2] = s_cx;
    assign in_y[2] = s_cy;
    assign in_z[2] = s_cz;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        tcp_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk  (aclk),
            .en    (en),
            .cfg   (cfg_reg),
            .in_x  (in_x[i]),
            .in_y  (in_y[i]),
            .in_z  (in_z[i]),
            .vx    (vx[i]),
            .vy    (vy[i]),
            .vz    (vz[i]),
            .sx    (sx[i]),
            .sy    (sy[i]),
            .fault (flt[i])
        );
    end

    tcp_merge #(.PAD(PAD)) u_merge (
        .aclk    (aclk),
        .en      (en),
        .vx      (vx),
        .vy      (vy),
        .vz      (vz),
        .visible (visible),
        .level   (level)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[LAT-1] && visible;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_out_reg <= tag_reg[LAT-1];
            for (int i = 0; i < 3; i++) begin
                sx_reg[i] <= sx[i];
                sy_reg[i] <= sy[i];
            end
            shade_reg <= level;
            fault_reg <= |flt;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_tag     = tag_out_reg;
    assign m_sx_a        = sx_reg[0];
    assign m_sy_a        = sy_reg[0];
    assign m_sx_b        = sx_reg[1];
    assign m_sy_b        = sy_reg[1];
    assign m_sx_c        = sx_reg[2];
    assign m_sy_c        = sy_reg[2];
    assign m_shade_level = shade_reg;
    assign m_depth_fault = fault_reg;

    `TCP_ASSERT_SAME(a_ready_when_empty, !m_valid_reg, s_ready, "input stalled with empty output")
    `TCP_ASSERT_SAME(a_result_from_pipe, $rose(m_valid_reg), $past(vld_reg[LAT-1]), "result without item")
    `TCP_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vld_reg), "pipeline moved while stalled")

endmodule
